// File: design/mmdu_pkg.sv
// ----------------------------------------------------------------------------
// mmdu_pkg: shared types and constants for the mapped multiply/divide unit
// Window region codes, bus commands, iteration counts and the control and
// status structs between the bus front end and the arithmetic core.
// ----------------------------------------------------------------------------
package mmdu_pkg;

   // Bus commands
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Window regions, taken from offset bits [4:3]
   localparam logic [1:0] RGN_QUOT = 2'b00;   // offsets 0-7
   localparam logic [1:0] RGN_OPER = 2'b01;   // offsets 8-15
   localparam logic [1:0] RGN_PROD = 2'b10;   // offsets 16-23
   localparam logic [1:0] RGN_NONE = 2'b11;   // offsets 24-31, outside the window

   // Operand and result widths
   localparam int OP_W     = 32;
   localparam int FRAC_W   = 32;
   localparam int RES_W    = 2 * OP_W;

   // Iteration counts of the shared unit
   localparam int MUL_STEPS = OP_W;
   localparam int DIV_STEPS = OP_W + FRAC_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

   // Front end to core
   typedef struct packed {
      logic start;
   } core_ctrl_type;

   // Core to front end
   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

endpackage

// File: design/mmdu_core.sv
// ----------------------------------------------------------------------------
// mmdu_core: iterative multiplier and divider on one shared add/subtract unit
// Runs 32 shift-add steps for the 64-bit product, then 64 restoring steps
// for the 32.32 quotient (A<<32)/B. A zero divisor yields all ones.
// ----------------------------------------------------------------------------
module mmdu_core
   import mmdu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  core_ctrl_type       ctrl,
   input  logic [OP_W-1:0]     opa,
   input  logic [OP_W-1:0]     opb,
   output core_stat_type       stat,
   output logic [RES_W-1:0]    product,
   output logic [RES_W-1:0]    quotient
);

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_MUL  = 2'd1;
   localparam logic [1:0] C_DIV  = 2'd2;
   localparam logic [1:0] C_DONE = 2'd3;

   localparam int ALU_W = OP_W + 2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [RES_W-1:0]  prod_ff, prod_in;
   logic [RES_W-1:0]  quot_ff, quot_in;
   logic [OP_W-1:0]   rem_ff, rem_in;

   logic              alu_sub;
   logic [ALU_W-1:0]  alu_x;
   logic [ALU_W-1:0]  alu_y;
   logic [ALU_W-1:0]  alu_res;
   logic              borrow;

   // Shared unit: add for the multiply, trial subtract for the divide
   assign alu_sub = (state_ff == C_DIV);
   assign alu_x   = alu_sub ? {1'b0, rem_ff, quot_ff[RES_W-1]}
                            : {2'b00, prod_ff[RES_W-1:OP_W]};
   assign alu_y   = {2'b00, opb};
   assign alu_res = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);
   assign borrow  = alu_res[ALU_W-1];

   // Sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      prod_in  = prod_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (ctrl.start) begin
               prod_in  = {{OP_W{1'b0}}, opa};
               quot_in  = {opa, {FRAC_W{1'b0}}};
               rem_in   = '0;
               count_in = '0;
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            // add B into the upper half when the multiplier bit is set, shift right
            if (prod_ff[0]) begin
               prod_in = {alu_res[OP_W:0], prod_ff[OP_W-1:1]};
            end else begin
               prod_in = {1'b0, prod_ff[RES_W-1:1]};
            end
            count_in = count_ff + 1'b1;
            if (count_ff == MUL_LAST) begin
               count_in = '0;
               state_in = C_DIV;
            end
         end
         C_DIV: begin
            // keep the difference when it does not borrow, shift in the quotient bit
            if (borrow) begin
               rem_in = alu_x[OP_W-1:0];
            end else begin
               rem_in = alu_res[OP_W-1:0];
            end
            quot_in  = {quot_ff[RES_W-2:0], ~borrow};
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_LAST) begin
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign stat.busy = (state_ff != C_IDLE);
   assign stat.done = (state_ff == C_DONE);
   assign product   = prod_ff;
   assign quotient  = quot_ff;

endmodule

// File: design/mapped_multiply_divide_unit.sv
// A write, a read outside the window or a read of fresh results
//   returns its byte in the cycle after the transfer.
// A read of stale results first runs 32 multiply steps and 64 divide
//   steps through one shared 34-bit add/subtract unit, plus load and finish.
// Throughput: one transfer in flight; the next is taken once the byte leaves.
// Reset clears operands to zero and marks the results stale.
// ----------------------------------------------------------------------------
// mapped_multiply_divide_unit: byte-wide bus-mapped multiplier and divider
// Holds operands A and B, recomputes the product and 32.32 quotient on the
// first read after reset or after any write in the window, and returns one byte per bus transfer.
// ----------------------------------------------------------------------------
module mapped_multiply_divide_unit
   import mmdu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [4:0]  req_reg_offset,
   input  logic [7:0]  req_write_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_byte
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CALC = 1'b1;

   logic              state_ff, state_in;
   logic [OP_W-1:0]   opa_ff, opa_in;
   logic [OP_W-1:0]   opb_ff, opb_in;
   logic              fresh_ff, fresh_in;
   logic [4:0]        off_ff, off_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;

   logic              accept;
   logic [4:0]        sel_off;
   logic [7:0]        sel_byte;
   core_ctrl_type     core_ctrl;
   core_stat_type     core_stat;
   logic [RES_W-1:0]  product;
   logic [RES_W-1:0]  quotient;

   mmdu_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (core_ctrl),
      .opa      (opa_ff),
      .opb      (opb_ff),
      .stat     (core_stat),
      .product  (product),
      .quotient (quotient)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Select the addressed window byte
   assign sel_off = (state_ff == ST_CALC) ? off_ff : req_reg_offset;

   always_comb begin
      unique case (sel_off[4:3])
         RGN_QUOT: sel_byte = quotient[{sel_off[2:0], 3'b000} +: 8];
         RGN_OPER: begin
            if (sel_off[2]) begin
               sel_byte = opb_ff[{sel_off[1:0], 3'b000} +: 8];
            end else begin
               sel_byte = opa_ff[{sel_off[1:0], 3'b000} +: 8];
            end
         end
         RGN_PROD: sel_byte = product[{sel_off[2:0], 3'b000} +: 8];
         RGN_NONE: sel_byte = 8'h00;
         default:  sel_byte = 8'h00;
      endcase
   end

   // Bus front end
   always_comb begin
      state_in        = state_ff;
      opa_in          = opa_ff;
      opb_in          = opb_ff;
      fresh_in        = fresh_ff;
      off_in          = off_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_byte_in     = rsp_byte_ff;
      core_ctrl.start = 1'b0;

      // drop the result once transferred
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               off_in = req_reg_offset;
               priority if (req_reg_offset[4:3] == RGN_NONE) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = 8'h00;
               end else if (req_cmd == CMD_WRITE) begin
                  // store operand bytes; any write in the window stales the results
                  if (req_reg_offset[4:3] == RGN_OPER) begin
                     if (req_reg_offset[2]) begin
                        opb_in[{req_reg_offset[1:0], 3'b000} +: 8] = req_write_byte;
                     end else begin
                        opa_in[{req_reg_offset[1:0], 3'b000} +: 8] = req_write_byte;
                     end
                  end
                  fresh_in     = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = 8'h00;
               end else if (fresh_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = sel_byte;
               end else begin
                  core_ctrl.start = 1'b1;
                  state_in        = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            // hold until the core finishes, then return the byte
            if (core_stat.done) begin
               fresh_in     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = sel_byte;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and operand registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         opa_ff       <= '0;
         opb_ff       <= '0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         opa_ff       <= opa_in;
         opb_ff       <= opb_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      off_ff      <= off_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;

   // Never take a transfer while the core is computing
   assert property (@(posedge clock) disable iff (reset)
      core_stat.busy |-> !req_ready)
      else $error("transfer accepted while core busy");

   // A finished computation leaves fresh results and a pending byte
   assert property (@(posedge clock) disable iff (reset)
      core_stat.done |=> fresh_ff && rsp_valid_ff)
      else $error("core done without fresh result");

   // A write in the window stales the results and returns zero
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_WRITE && req_reg_offset[4:3] != RGN_NONE)
      |=> !fresh_ff && rsp_valid_ff && rsp_byte_ff == 8'h00)
      else $error("write did not stale results");

   // No result is pending while computing
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> !rsp_valid_ff)
      else $error("result pending during computation");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the mapped multiply/divide unit
// Sends byte reads and writes in and past the 24-byte window and predicts each
// returned byte from a local copy of the operands and the cached product and
// quotient. Every response transfer is checked in order while the sender and
// the receiver insert random gaps.
// ----------------------------------------------------------------------------
module tb;
   import mmdu_pkg::*;

   localparam int ITEM_TARGET  = 1600;
   localparam int STUCK_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES  = 400;

   // Window model and queue of expected response bytes
   class window_byte_scoreboard;
      logic [31:0] opnd_a;
      logic [31:0] opnd_b;
      logic [63:0] prod;
      logic [63:0] quot;
      logic        fresh;
      logic [7:0]  expected_bytes[$];
      int unsigned fail_count;

      function new();
         opnd_a     = '0;
         opnd_b     = '0;
         prod       = '0;
         quot       = '0;
         fresh      = 1'b0;
         fail_count = 0;
      endfunction

      // Apply one accepted access and queue the byte it returns
      function void note_transfer(logic cmd, logic [4:0] offset, logic [7:0] data);
         logic [7:0] rd_byte;
         rd_byte = 8'h00;
         if (offset[4:3] != RGN_NONE) begin
            if (cmd == CMD_WRITE) begin
               if (offset[4:3] == RGN_OPER) begin
                  if (offset[2]) opnd_b[offset[1:0]*8 +: 8] = data;
                  else opnd_a[offset[1:0]*8 +: 8] = data;
               end
               fresh = 1'b0;
            end else begin
               // recompute both results on a read of stale values
               if (!fresh) begin
                  prod = {32'h0, opnd_a} * {32'h0, opnd_b};
                  if (opnd_b == '0) quot = '1;
                  else quot = {opnd_a, 32'h0} / {32'h0, opnd_b};
                  fresh = 1'b1;
               end
               case (offset[4:3])
                  RGN_QUOT: rd_byte = quot[offset[2:0]*8 +: 8];
                  RGN_OPER: begin
                     if (offset[2]) rd_byte = opnd_b[offset[1:0]*8 +: 8];
                     else rd_byte = opnd_a[offset[1:0]*8 +: 8];
                  end
                  default: rd_byte = prod[offset[2:0]*8 +: 8];
               endcase
            end
         end
         expected_bytes.push_back(rd_byte);
      endfunction

      // Compare one response transfer with the oldest expectation
      function void check_read_byte(logic [7:0] actual);
         logic [7:0] want;
         if (expected_bytes.size() == 0) begin
            $error("read_byte: unexpected transfer, actual %02h", actual);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (actual !== want) begin
               $error("read_byte: expected %02h, actual %02h", want, actual);
               fail_count++;
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_cmd = CMD_READ;
   logic [4:0] req_reg_offset = '0;
   logic [7:0] req_write_byte = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_byte;

   window_byte_scoreboard board = new();

   int send_idle_pct  = 11;
   int recv_stall_pct = 56;
   int sent_count     = 0;
   bit hold_off_req   = 1'b0;
   int stuck_cycles   = 0;

   mapped_multiply_divide_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_reg_offset (req_reg_offset),
      .req_write_byte (req_write_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_byte  (rsp_read_byte)
   );

   always #4 clock = ~clock;

   // Offer one access, hold it until the transfer, then note it
   task automatic send_access(input logic cmd, input logic [4:0] offset,
                              input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_reg_offset <= offset;
      req_write_byte <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_transfer(cmd, offset, data);
      sent_count++;
   endtask

   // Load a whole operand, lanes in ascending order
   task automatic write_operand(input logic sel_b, input logic [31:0] value);
      for (int lane = 0; lane < 4; lane++) begin
         send_access(CMD_WRITE, {2'b01, sel_b, 2'(lane)}, value[lane*8 +: 8]);
      end
   endtask

   // Bias bytes toward the all-zero and all-one extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'($urandom_range(255));
         default: return $urandom;
      endcase
   endfunction

   // Receiver: check each response transfer and drive ready
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready) board.check_read_byte(rsp_read_byte);
         if (hold_off_req) begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: end the run when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      int         kind;
      int         count;
      bit         pressure_done;
      logic [4:0] offset;
      pressure_done = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stale read after reset with B at zero, then extremes
      send_access(CMD_READ, 5'd0, 8'hFF);
      send_access(CMD_READ, 5'd16, 8'h00);
      write_operand(1'b0, 32'hFFFF_FFFF);
      write_operand(1'b1, 32'h0000_0001);
      send_access(CMD_READ, 5'd4, 8'h00);
      send_access(CMD_READ, 5'd7, 8'hFF);
      send_access(CMD_READ, 5'd16, 8'h00);
      send_access(CMD_READ, 5'd23, 8'hFF);
      write_operand(1'b1, 32'hFFFF_FFFF);
      send_access(CMD_READ, 5'd3, 8'h00);
      send_access(CMD_READ, 5'd23, 8'h00);
      // write into a result byte, then past the window
      send_access(CMD_WRITE, 5'd20, 8'h5A);
      send_access(CMD_READ, 5'd20, 8'hA5);
      send_access(CMD_WRITE, 5'd31, 8'hAA);
      send_access(CMD_READ, 5'd24, 8'h55);
      send_access(CMD_READ, 5'd11, 8'h00);

      // random: mostly operand loads followed by result reads
      while (sent_count < ITEM_TARGET) begin
         if (sent_count < ITEM_TARGET / 3) begin
            send_idle_pct  = 11;
            recv_stall_pct = 56;
         end else if (sent_count < 2 * ITEM_TARGET / 3) begin
            send_idle_pct  = 56;
            recv_stall_pct = 11;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         if (!pressure_done && sent_count >= 400) begin
            hold_off_req  = 1'b1;
            pressure_done = 1'b1;
         end

         kind = $urandom_range(99);
         if (kind < 70) begin
            if ($urandom_range(1)) write_operand(1'b0, pick_word());
            if ($urandom_range(1)) write_operand(1'b1, pick_word());
            count = $urandom_range(3);
            repeat (count) send_access(CMD_WRITE, 5'(8 + $urandom_range(7)), pick_byte());
            count = $urandom_range(6, 1);
            repeat (count) send_access(CMD_READ, 5'($urandom_range(23)), pick_byte());
         end else if (kind < 85) begin
            send_access(1'($urandom_range(1)), 5'($urandom_range(31)), 8'($urandom));
         end else begin
            // write outside the operands, then read anywhere in the window
            offset = 5'($urandom_range(31));
            if (offset[4:3] == RGN_OPER) offset[4:3] = RGN_PROD;
            send_access(CMD_WRITE, offset, pick_byte());
            send_access(CMD_READ, 5'($urandom_range(23)), pick_byte());
         end
      end

      // drain
      req_valid <= 1'b0;
      while (board.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fail_count == 0 && board.expected_bytes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
